FILE: src/adne_pkg.sv
// Shared types, constants and helpers for the advertising data name extractor.
// No dependencies; the front end, queue, back end and core import this package.
`default_nettype none

package adne_pkg;

    // Defaults for the top-level parameters
    localparam int NAME_CAPACITY_DEF    = 64;
    localparam int MAX_REPORT_BYTES_DEF = 1024;

    // Fixed field widths
    localparam int LEN_W  = 10;   // report_length
    localparam int BYTE_W = 8;    // data_byte
    localparam int CHAR_W = 7;    // name_char
    localparam int IDX_W  = 6;    // char_index and name_length

    // Stream bus widths, rounded up to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // Deepest name store that the 6-bit index fields can address
    localparam int STORE_DEPTH_MAX = 63;

    // Depth of the emit command queue between front and back
    localparam int CMD_FIFO_DEPTH = 2;

    // Input word kinds (carried on tuser)
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    // Advertising data structure types that carry a local name
    localparam logic [BYTE_W-1:0] AD_TYPE_SHORT_NAME    = 8'h08;
    localparam logic [BYTE_W-1:0] AD_TYPE_COMPLETE_NAME = 8'h09;

    // Printable range and the replacement character
    localparam logic [BYTE_W-1:0] CHAR_FIRST_PRINT = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_DEL         = 8'h7f;
    localparam logic [CHAR_W-1:0] CHAR_DOT         = 7'h2e;

    // Emit request from the parser: a name of name_len characters is due
    typedef struct packed {
        logic             push;
        logic [IDX_W-1:0] name_len;
    } emit_cmd_t;

    // Map a raw byte to a stored name character
    function automatic logic [CHAR_W-1:0] to_name_char(input logic [BYTE_W-1:0] b);
        logic [CHAR_W-1:0] c;
        if (b >= CHAR_FIRST_PRINT && b < CHAR_DEL) begin
            c = b[CHAR_W-1:0];
        end else begin
            c = CHAR_DOT;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: src/adne_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module adne_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/adne_front.sv
// Parser front end: accepts input words, walks the length-type-value structures,
// writes name characters into the store and requests emission. Uses adne_pkg.
`default_nettype none

module adne_front #(
    parameter int MAX_REPORT_BYTES = adne_pkg::MAX_REPORT_BYTES_DEF,
    parameter int STORE_DEPTH      = adne_pkg::STORE_DEPTH_MAX,
    parameter int AW               = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_accept,
    input  wire logic                         in_kind,
    input  wire logic [adne_pkg::LEN_W-1:0]   in_report_length,
    input  wire logic [adne_pkg::BYTE_W-1:0]  in_data_byte,
    output logic                              wr_possible,
    output logic                              store_we,
    output logic [AW-1:0]                     store_waddr,
    output logic [adne_pkg::CHAR_W-1:0]       store_wdata,
    output adne_pkg::emit_cmd_t               emit_cmd
);
    import adne_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_LEN, PH_BODY, PH_STOP} phase_t;

    localparam logic [LEN_W-1:0] MAX_LEN =
        (MAX_REPORT_BYTES > 1023) ? {LEN_W{1'b1}} : LEN_W'(MAX_REPORT_BYTES);

    phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [BYTE_W-1:0] field_reg, field_next;
    logic [BYTE_W-1:0] body_reg, body_next;
    logic              cap_active_reg, cap_active_next;
    logic              complete_reg, complete_next;
    logic [IDX_W-1:0]  limit_reg, limit_next;
    logic [IDX_W-1:0]  held_reg, held_next;

    logic [LEN_W-1:0]  len_clamped;
    logic [LEN_W:0]    struct_end;
    logic [BYTE_W-1:0] flen_m1;
    logic [BYTE_W-1:0] body_idx;

    assign wr_possible = (phase_reg == PH_BODY) && cap_active_reg && (body_reg != '0);

    always_comb begin
        len_clamped = (int'(in_report_length) > MAX_REPORT_BYTES) ? MAX_LEN : in_report_length;
        struct_end  = {1'b0, pos_reg} + {{(LEN_W + 1 - BYTE_W){1'b0}}, in_data_byte};
        flen_m1     = field_reg - 8'd1;
        body_idx    = body_reg - 8'd1;

        phase_next      = phase_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        field_next      = field_reg;
        body_next       = body_reg;
        cap_active_next = cap_active_reg;
        complete_next   = complete_reg;
        limit_next      = limit_reg;
        held_next       = held_reg;

        store_we    = 1'b0;
        store_waddr = body_idx[AW-1:0];
        store_wdata = to_name_char(in_data_byte);
        emit_cmd.push = 1'b0;

        if (in_accept) begin
            if (in_kind == KIND_START) begin
                // Drop any open report and start a new one
                held_next       = '0;
                cap_active_next = 1'b0;
                complete_next   = 1'b0;
                limit_next      = '0;
                field_next      = '0;
                body_next       = '0;
                pos_next        = '0;
                len_next        = len_clamped;
                if (len_clamped == '0) begin
                    phase_next    = PH_IDLE;
                    emit_cmd.push = 1'b1;
                end else begin
                    phase_next = PH_LEN;
                end
            end else if (phase_reg != PH_IDLE) begin
                unique case (phase_reg)
                    PH_LEN: begin
                        if (in_data_byte == '0 || struct_end >= {1'b0, len_reg}) begin
                            phase_next = PH_STOP;
                        end else begin
                            field_next      = in_data_byte;
                            body_next       = '0;
                            cap_active_next = 1'b0;
                            phase_next      = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        if (body_reg == '0) begin
                            // Type byte: open a capture for a name with a body
                            if ((in_data_byte == AD_TYPE_SHORT_NAME ||
                                 in_data_byte == AD_TYPE_COMPLETE_NAME) && field_reg > 8'd1) begin
                                cap_active_next = 1'b1;
                                limit_next = (flen_m1 > BYTE_W'(STORE_DEPTH)) ?
                                             IDX_W'(STORE_DEPTH) : flen_m1[IDX_W-1:0];
                                held_next     = limit_next;
                                complete_next = (in_data_byte == AD_TYPE_COMPLETE_NAME);
                            end else begin
                                cap_active_next = 1'b0;
                            end
                        end else if (cap_active_reg) begin
                            if (body_idx < {{(BYTE_W - IDX_W){1'b0}}, limit_reg}) begin
                                store_we = 1'b1;
                            end
                        end
                        body_next  = body_reg + 8'd1;
                        field_next = field_reg - 8'd1;
                        if (field_next == '0) begin
                            phase_next = (cap_active_next && complete_next) ? PH_STOP : PH_LEN;
                            cap_active_next = 1'b0;
                            body_next       = '0;
                        end
                    end
                    default: begin
                    end
                endcase
                pos_next = pos_reg + 10'd1;
                if (pos_next >= len_reg) begin
                    phase_next    = PH_IDLE;
                    emit_cmd.push = 1'b1;
                end
            end
        end
        emit_cmd.name_len = held_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            pos_reg        <= '0;
            len_reg        <= '0;
            field_reg      <= '0;
            body_reg       <= '0;
            cap_active_reg <= 1'b0;
            complete_reg   <= 1'b0;
            limit_reg      <= '0;
            held_reg       <= '0;
        end else begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            len_reg        <= len_next;
            field_reg      <= field_next;
            body_reg       <= body_next;
            cap_active_reg <= cap_active_next;
            complete_reg   <= complete_next;
            limit_reg      <= limit_next;
            held_reg       <= held_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/adne_cmd_fifo.sv
// Short queue of emit commands between parser and emitter.
// Uses adne_pkg.
`default_nettype none

module adne_cmd_fifo #(
    parameter int DEPTH = adne_pkg::CMD_FIFO_DEPTH
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire adne_pkg::emit_cmd_t         push_cmd,
    input  wire logic                        pop,
    output logic                             full,
    output logic                             not_empty,
    output logic [adne_pkg::IDX_W-1:0]       head_len
);
    import adne_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [IDX_W-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_len  = slot_reg[rd_ptr_reg];

    always_comb begin
        do_push     = push_cmd.push && !full;
        do_pop      = pop && not_empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd.name_len;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/adne_back.sv
// Emitter back end: pops emit commands, reads the name store one character per
// cycle while not stalled, drives the result stream via an output register. Uses adne_pkg.
`default_nettype none

module adne_back #(
    parameter int STORE_DEPTH = adne_pkg::STORE_DEPTH_MAX,
    parameter int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cmd_valid,
    input  wire logic [adne_pkg::IDX_W-1:0]   cmd_len,
    output logic                              cmd_pop,
    output logic                              active,
    output logic                              store_re,
    output logic [AW-1:0]                     store_raddr,
    input  wire logic [adne_pkg::CHAR_W-1:0]  store_rdata,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [adne_pkg::CHAR_W-1:0]       out_char,
    output logic [adne_pkg::IDX_W-1:0]        out_index,
    output logic [adne_pkg::IDX_W-1:0]        out_length,
    output logic                              out_last
);
    import adne_pkg::*;

    // Walk state
    logic             active_reg, active_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] len_reg, len_next;
    // Read stage: store data lands in the RAM output register
    logic             s1_valid_reg, s1_valid_next;
    logic [IDX_W-1:0] s1_idx_reg, s1_idx_next;
    logic [IDX_W-1:0] s1_len_reg, s1_len_next;
    logic             s1_last_reg, s1_last_next;
    logic             s1_empty_reg, s1_empty_next;
    // Output stage
    logic              o_valid_reg, o_valid_next;
    logic [CHAR_W-1:0] o_char_reg, o_char_next;
    logic [IDX_W-1:0]  o_idx_reg, o_idx_next;
    logic [IDX_W-1:0]  o_len_reg, o_len_next;
    logic              o_last_reg, o_last_next;

    logic             advance;
    logic [IDX_W-1:0] rd_idx;

    assign advance     = !o_valid_reg || out_ready;
    assign store_re    = advance;
    assign store_raddr = rd_idx[AW-1:0];
    assign active      = active_reg;
    assign out_valid   = o_valid_reg;
    assign out_char    = o_char_reg;
    assign out_index   = o_idx_reg;
    assign out_length  = o_len_reg;
    assign out_last    = o_last_reg;

    always_comb begin
        active_next   = active_reg;
        idx_next      = idx_reg;
        len_next      = len_reg;
        s1_valid_next = s1_valid_reg;
        s1_idx_next   = s1_idx_reg;
        s1_len_next   = s1_len_reg;
        s1_last_next  = s1_last_reg;
        s1_empty_next = s1_empty_reg;
        o_valid_next  = o_valid_reg;
        o_char_next   = o_char_reg;
        o_idx_next    = o_idx_reg;
        o_len_next    = o_len_reg;
        o_last_next   = o_last_reg;
        cmd_pop       = 1'b0;
        rd_idx        = idx_reg;

        if (advance) begin
            o_valid_next  = s1_valid_reg;
            o_char_next   = s1_empty_reg ? '0 : store_rdata;
            o_idx_next    = s1_idx_reg;
            o_len_next    = s1_len_reg;
            o_last_next   = s1_last_reg;
            s1_valid_next = 1'b0;
            if (active_reg) begin
                s1_valid_next = 1'b1;
                s1_idx_next   = idx_reg;
                s1_len_next   = len_reg;
                s1_empty_next = 1'b0;
                s1_last_next  = ({1'b0, idx_reg} + 7'd1) == {1'b0, len_reg};
                idx_next      = idx_reg + 6'd1;
                if (s1_last_next) begin
                    active_next = 1'b0;
                end
            end else if (cmd_valid) begin
                cmd_pop       = 1'b1;
                rd_idx        = '0;
                s1_valid_next = 1'b1;
                s1_idx_next   = '0;
                s1_len_next   = cmd_len;
                s1_empty_next = (cmd_len == '0);
                s1_last_next  = (cmd_len <= 6'd1);
                active_next   = (cmd_len > 6'd1);
                idx_next      = 6'd1;
                len_next      = cmd_len;
            end
        end
    end

    always_ff @(posedge aclk) begin
        s1_idx_reg   <= s1_idx_next;
        s1_len_reg   <= s1_len_next;
        s1_last_reg  <= s1_last_next;
        s1_empty_reg <= s1_empty_next;
        o_char_reg   <= o_char_next;
        o_idx_reg    <= o_idx_next;
        o_len_reg    <= o_len_next;
        o_last_reg   <= o_last_next;
        idx_reg      <= idx_next;
        len_reg      <= len_next;
        if (!aresetn) begin
            active_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end else begin
            active_reg   <= active_next;
            s1_valid_reg <= s1_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/adv_data_name_extractor_core.sv
// Path: the word that closes a report (final data byte, or a start with length
//   zero) queues an emit request; the name is read out through the output register.
// Throughput: one input word per cycle and one result word per cycle while m_tready
//   is high; the input stalls while a name body byte waits for an earlier name to be
//   read out of the name store, or while the two-entry emit queue is full.
// Reset: synchronous, active low; clears parser, queue and emitter control. The
//   name store is not cleared.
`default_nettype none

module adv_data_name_extractor_core #(
    parameter int NAME_CAPACITY    = adne_pkg::NAME_CAPACITY_DEF,
    parameter int MAX_REPORT_BYTES = adne_pkg::MAX_REPORT_BYTES_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [adne_pkg::S_TDATA_W-1:0]  s_tdata,  // report_length[9:0], data_byte[17:10]
    input  wire logic                            s_tuser,  // kind: 0 start, 1 data byte
    // Result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [adne_pkg::M_TDATA_W-1:0]       m_tdata,  // name_char[6:0], char_index[12:7],
                                                           // name_length[18:13]
    output logic                                 m_tlast   // last character of the name
);
    import adne_pkg::*;

    // Store holds at most one character less than the capacity, capped by the index width
    localparam int STORE_DEPTH = (NAME_CAPACITY - 1 > STORE_DEPTH_MAX) ?
                                 STORE_DEPTH_MAX : NAME_CAPACITY - 1;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic              in_accept;
    logic              wr_possible;
    logic              store_we;
    logic [AW-1:0]     store_waddr;
    logic [CHAR_W-1:0] store_wdata;
    logic              store_re;
    logic [AW-1:0]     store_raddr;
    logic [CHAR_W-1:0] store_rdata;
    emit_cmd_t         emit_cmd;
    logic              q_full, q_not_empty, q_pop;
    logic [IDX_W-1:0]  q_len;
    logic              back_active;
    logic              store_busy;
    logic [CHAR_W-1:0] out_char;
    logic [IDX_W-1:0]  out_index, out_length;

    // Hold off name writes while an earlier name is queued or being read out,
    // and hold all input while the queue cannot take another emit request.
    assign store_busy = back_active || q_not_empty;
    assign s_tready   = !q_full && !(wr_possible && store_busy);
    assign in_accept  = s_tvalid && s_tready;

    adne_front #(
        .MAX_REPORT_BYTES(MAX_REPORT_BYTES),
        .STORE_DEPTH     (STORE_DEPTH),
        .AW              (AW)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_accept       (in_accept),
        .in_kind         (s_tuser),
        .in_report_length(s_tdata[LEN_W-1:0]),
        .in_data_byte    (s_tdata[LEN_W +: BYTE_W]),
        .wr_possible     (wr_possible),
        .store_we        (store_we),
        .store_waddr     (store_waddr),
        .store_wdata     (store_wdata),
        .emit_cmd        (emit_cmd)
    );

    adne_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(STORE_DEPTH),
        .AW   (AW)
    ) u_name_store (
        .aclk (aclk),
        .we   (store_we),
        .waddr(store_waddr),
        .wdata(store_wdata),
        .re   (store_re),
        .raddr(store_raddr),
        .rdata(store_rdata)
    );

    adne_cmd_fifo #(
        .DEPTH(CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cmd (emit_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .not_empty(q_not_empty),
        .head_len (q_len)
    );

    adne_back #(
        .STORE_DEPTH(STORE_DEPTH),
        .AW         (AW)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (q_not_empty),
        .cmd_len    (q_len),
        .cmd_pop    (q_pop),
        .active     (back_active),
        .store_re   (store_re),
        .store_raddr(store_raddr),
        .store_rdata(store_rdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (out_char),
        .out_index  (out_index),
        .out_length (out_length),
        .out_last   (m_tlast)
    );

    // Pack the result word, low field first, zero-filled to whole bytes
    assign m_tdata = {{(M_TDATA_W - CHAR_W - 2 * IDX_W){1'b0}}, out_length, out_index, out_char};

endmodule

`default_nettype wire

FILE: src/adne_checker.sv
// Port-level checker for the name extractor result stream, bound to the top level.
// Depends on adv_data_name_extractor_core.
`default_nettype none

module adne_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast
);

    logic [6:0] idx_p1;
    logic [6:0] len_w;

    assign idx_p1 = {1'b0, m_tdata[12:7]} + 7'd1;
    assign len_w  = {1'b0, m_tdata[18:13]};

    // Stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // Last character sits at position length minus one, or the name is empty
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (idx_p1 == len_w) || (len_w == 7'd0))
        else $error("last flag at wrong position");

    // Non-final characters lie strictly inside the name
    a_inner_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> idx_p1 < len_w)
        else $error("character index outside name");

    // Empty name is a single zero word marked last
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[18:13] == 6'd0) |-> m_tlast && (m_tdata[12:0] == 13'd0))
        else $error("malformed empty-name word");

    // After a final word is taken, the next word starts a new name at position zero
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast ##1 m_tvalid |-> m_tdata[12:7] == 6'd0)
        else $error("new name does not start at position zero");

endmodule

bind adv_data_name_extractor_core adne_checker u_adne_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

`default_nettype wire
